// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL, clocked on clk_i with rst_ni gating.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/lbsc_pkg.sv
// ----------------------------------------------------------------------------
// lbsc_pkg
// Types, codes and panel origin tables for the LED frame store core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbsc_pkg;

  // Operation codes
  localparam logic [2:0] OP_WR_BYTE   = 3'd0;
  localparam logic [2:0] OP_RD_BYTE   = 3'd1;
  localparam logic [2:0] OP_WR_PIX    = 3'd2;
  localparam logic [2:0] OP_RD_PIX    = 3'd3;
  localparam logic [2:0] OP_PANEL_PIX = 3'd4;
  localparam logic [2:0] OP_REFRESH   = 3'd5;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Register indexes (paddr bit 2)
  localparam logic REG_BPC   = 1'b0;
  localparam logic REG_CHAIN = 1'b1;

  // Register reset values
  localparam logic [3:0] BPC_RESET   = 4'd7;
  localparam logic [6:0] CHAIN_RESET = 7'd7;

  // Width of a computed byte offset: (255 * 15) + 31 fits, as does 4096
  localparam int unsigned OFF_W = 13;

  localparam logic [4:0] NUM_PANELS = 5'd22;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESP,
    ST_REF
  } state_e;

  // Row origin of each panel
  function automatic logic [7:0] panel_row_org(input logic [4:0] panel);
    logic [7:0] org;
    case (panel)
      5'd0, 5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19: org = 8'd1;
      5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20:       org = 8'd17;
      5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21:       org = 8'd39;
      default:                                             org = 8'd0;
    endcase
    return org;
  endfunction

  // Column origin of each panel
  function automatic logic [7:0] panel_col_org(input logic [4:0] panel);
    logic [7:0] org;
    case (panel)
      5'd0, 5'd1, 5'd2, 5'd3:  org = 8'd1;
      5'd4, 5'd5, 5'd6:        org = 8'd6;
      5'd7, 5'd8, 5'd9:        org = 8'd12;
      5'd10, 5'd11, 5'd12:     org = 8'd18;
      5'd13, 5'd14, 5'd15:     org = 8'd24;
      5'd16, 5'd17, 5'd18:     org = 8'd30;
      5'd19, 5'd20, 5'd21:     org = 8'd36;
      default:                 org = 8'd0;
    endcase
    return org;
  endfunction

endpackage

`default_nettype wire

// File: rtl/lbsc_ram.sv
// ----------------------------------------------------------------------------
// lbsc_ram
// Single-port synchronous RAM with registered read data (read-first).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbsc_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 512,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, register the read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

`default_nettype wire

// File: rtl/led_bitmap_store_and_chain_refresh_core.sv
// ----------------------------------------------------------------------------
// led_bitmap_store_and_chain_refresh_core
// Column-major LED frame store with byte/pixel access and shift chain refresh.
//
//   channel   direction  ports                                  handshake
//   item      in         op/row/col/panel/value/count_i         start & !busy
//   result    out        data_out_o/status_o/last_o             done_o strobe
//   config    in/out     psel/penable/pwrite/paddr/pwdata/...   APB, pready=1
//
// Ops 0 to 4 and rejected items: the accept cycle issues the frame store
// access, the next one shows the result and writes back a pixel (ops 2, 4).
// Refresh of n bytes makes one store read per result byte.
// After reset a clearing pass zeroes the store with busy high;
// configuration writes are taken throughout.
// Results leave on a one-cycle strobe and cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module led_bitmap_store_and_chain_refresh_core #(
  parameter int unsigned STORE_BYTES = 512,
  parameter int unsigned MAX_CHAIN   = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // item port
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  op_i,
  input  wire logic [6:0]  row_i,
  input  wire logic [6:0]  col_i,
  input  wire logic [4:0]  panel_i,
  input  wire logic [7:0]  value_i,
  input  wire logic [6:0]  count_i,
  // result port
  output logic             done_o,
  output logic [7:0]       data_out_o,
  output logic [1:0]       status_o,
  output logic             last_o,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  import lbsc_pkg::*;

  localparam int unsigned   ADDR_W    = $clog2(STORE_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
  localparam logic [ADDR_W-1:0] ADDR_ONE  = ADDR_W'(1);
  localparam logic [OFF_W:0]    STORE_LIM = (OFF_W + 1)'(STORE_BYTES);
  localparam logic [6:0]        MAX_LEN   = 7'(MAX_CHAIN);

  // Configuration registers
  logic [3:0] bpc_q;
  logic [6:0] chain_q;

  // Control state
  state_e            state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [ADDR_W-1:0] refa_q, refa_d;
  logic              ok_q;

  // Item payload held for the response cycle
  logic [2:0]        op_q;
  logic [ADDR_W-1:0] off_q;
  logic [2:0]        bit_q;
  logic              pix_q;
  logic [1:0]        stat_q;

  // Address path
  logic [7:0]       grow, gcol, grow_m1, gcol_m1;
  logic [4:0]       bidx;
  logic [11:0]      prod;
  logic [OFF_W-1:0] loc_off;
  logic             loc_ok;
  logic [6:0]       len_raw, ref_len;
  logic [1:0]       item_stat;
  logic             load;

  // RAM port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic [7:0]        pix_mask;

  // --------------------------------------------------------------------------
  // Configuration port: always ready, write on access phase
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpc_q   <= BPC_RESET;
      chain_q <= CHAIN_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_BPC) begin
        bpc_q <= pwdata[3:0];
      end else begin
        chain_q <= pwdata[6:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_CHAIN) begin
      prdata = {25'd0, chain_q};
    end else begin
      prdata = {28'd0, bpc_q};
    end
  end

  // --------------------------------------------------------------------------
  // Locate the addressed byte, translating panel coordinates for op 4
  // --------------------------------------------------------------------------
  always_comb begin
    if (op_i == OP_PANEL_PIX) begin
      grow = {1'b0, row_i} + panel_row_org(panel_i) - 8'd1;
      gcol = {1'b0, col_i} + panel_col_org(panel_i) - 8'd1;
    end else begin
      grow = {1'b0, row_i};
      gcol = {1'b0, col_i};
    end
    grow_m1 = grow - 8'd1;
    gcol_m1 = gcol - 8'd1;
    bidx    = grow_m1[7:3];
    prod    = {4'd0, gcol_m1} * {8'd0, bpc_q};
    loc_off = {1'b0, prod} + {8'd0, bidx};
    loc_ok  = (row_i != 7'd0) && (col_i != 7'd0) && (grow != 8'd0) && (gcol != 8'd0)
              && (bidx < {1'b0, bpc_q}) && ({1'b0, loc_off} < STORE_LIM);
    if (op_i == OP_PANEL_PIX && panel_i >= NUM_PANELS) begin
      loc_ok = 1'b0;
    end
  end

  // Refresh length; the user must keep MAX_CHAIN within the store depth, the block itself does not enforce it
  always_comb begin
    len_raw = (count_i == 7'd0) ? chain_q : count_i;
    ref_len = (len_raw > MAX_LEN) ? MAX_LEN : len_raw;
  end

  // Status of an accepted item
  always_comb begin
    case (op_i)
      OP_WR_BYTE, OP_RD_BYTE, OP_WR_PIX, OP_RD_PIX, OP_PANEL_PIX: begin
        item_stat = loc_ok ? STAT_OK : STAT_RANGE;
      end
      OP_REFRESH: begin
        item_stat = (ref_len == 7'd0) ? STAT_EMPTY : STAT_OK;
      end
      default: begin
        item_stat = STAT_RANGE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Frame store
  // --------------------------------------------------------------------------
  lbsc_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign pix_mask = 8'd1 << bit_q;

  // --------------------------------------------------------------------------
  // Sequencer: next state, store access and result
  // --------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    refa_d     = refa_q;
    load       = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = loc_off[ADDR_W-1:0];
    ram_wdata  = value_i;
    done_o     = 1'b0;
    data_out_o = 8'd0;
    status_o   = STAT_OK;
    last_o     = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = 8'd0;
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + ADDR_ONE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          load = 1'b1;
          if (op_i == OP_REFRESH && item_stat == STAT_OK) begin
            // first chain byte is the highest address
            ram_addr = ADDR_W'(ref_len - 7'd1);
            refa_d   = ADDR_W'(ref_len - 7'd1);
            state_d  = ST_REF;
          end else begin
            ram_we  = (op_i == OP_WR_BYTE) && loc_ok;
            state_d = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        done_o   = 1'b1;
        last_o   = 1'b1;
        status_o = stat_q;
        state_d  = ST_IDLE;
        if (ok_q) begin
          case (op_q)
            OP_RD_BYTE: begin
              data_out_o = ram_rdata;
            end
            OP_RD_PIX: begin
              data_out_o = {7'd0, ram_rdata[bit_q]};
            end
            OP_WR_PIX, OP_PANEL_PIX: begin
              // write back the modified byte
              ram_we    = 1'b1;
              ram_addr  = off_q;
              ram_wdata = pix_q ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
            end
            default: begin
              data_out_o = 8'd0;
            end
          endcase
        end
      end
      ST_REF: begin
        done_o     = 1'b1;
        data_out_o = ~ram_rdata;
        last_o     = (refa_q == '0);
        ram_addr   = refa_q - ADDR_ONE;
        if (refa_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          refa_d = refa_q - ADDR_ONE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      refa_q  <= '0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      refa_q  <= refa_d;
      if (load) begin
        ok_q <= (item_stat == STAT_OK);
      end
    end
  end

  // Capture the item payload on accept
  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q   <= op_i;
      off_q  <= loc_off[ADDR_W-1:0];
      bit_q  <= grow_m1[2:0];
      pix_q  <= value_i[0];
      stat_q <= item_stat;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `ASSERT_ALWAYS(a_idle_quiet, !busy |-> !done_o, "result strobe while idle")
  `ASSERT_NEXT(a_stream_gapless, done_o && !last_o, done_o && status_o == STAT_OK,
               "refresh stream broke before its last byte")
  `ASSERT_NEXT(a_last_frees, done_o && last_o, !busy, "block stayed busy after last result")

endmodule

`default_nettype wire
